[sv/pbps_pkg.sv]
`timescale 1ns / 1ps
package pbps_pkg;

  localparam int MAX_BOXES = 32;
  localparam int ADDR_W    = $clog2(MAX_BOXES);
  localparam int SLOT_W    = 5;
  localparam int CNT_W     = SLOT_W + 1;
  localparam int COORD_W   = 16;
  localparam int GAP_W     = COORD_W + 1;
  localparam int PROD_W    = 2 * GAP_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int R2_W      = 2 * COORD_W;
  localparam int BOX_W     = 6 * COORD_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RSQ   = 6'b000010,
    S_READ  = 6'b000100,
    S_AXIS  = 6'b001000,
    S_CMP   = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  typedef struct packed {
    logic       load_q;
    logic       sq_radius;
    logic       gap_en;
    logic       acc_clr;
    logic       acc_en;
    logic [1:0] axis;
  } dist_ctrl_t;

  typedef struct packed {
    logic match;
    logic r_neg;
  } dist_stat_t;

endpackage

[sv/pbps_if.sv]
`timescale 1ns / 1ps
interface pbps_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic [pbps_pkg::SLOT_W-1:0]          slot;
  logic signed [pbps_pkg::COORD_W-1:0]  box_min_x;
  logic signed [pbps_pkg::COORD_W-1:0]  box_min_y;
  logic signed [pbps_pkg::COORD_W-1:0]  box_min_z;
  logic signed [pbps_pkg::COORD_W-1:0]  box_max_x;
  logic signed [pbps_pkg::COORD_W-1:0]  box_max_y;
  logic signed [pbps_pkg::COORD_W-1:0]  box_max_z;
  logic signed [pbps_pkg::COORD_W-1:0]  point_x;
  logic signed [pbps_pkg::COORD_W-1:0]  point_y;
  logic signed [pbps_pkg::COORD_W-1:0]  point_z;
  logic signed [pbps_pkg::COORD_W-1:0]  radius;

  modport source (
    output valid, op, slot, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, point_x, point_y, point_z, radius,
    input  ready
  );
  modport sink (
    input  valid, op, slot, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, point_x, point_y, point_z, radius,
    output ready
  );
endinterface

interface pbps_out_if;
  logic                        valid;
  logic                        ready;
  logic [pbps_pkg::SLOT_W-1:0] box_index;
  logic                        hit;
  logic                        last;

  modport source (output valid, box_index, hit, last, input ready);
  modport sink (input valid, box_index, hit, last, output ready);
endinterface

[sv/pbps_ram.sv]
`timescale 1ns / 1ps
module pbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/pbps_dist_unit.sv]
`timescale 1ns / 1ps
module pbps_dist_unit (
  input  logic                                 clk,
  input  pbps_pkg::dist_ctrl_t                 ctrl,
  input  logic signed [pbps_pkg::COORD_W-1:0]  point_x,
  input  logic signed [pbps_pkg::COORD_W-1:0]  point_y,
  input  logic signed [pbps_pkg::COORD_W-1:0]  point_z,
  input  logic signed [pbps_pkg::COORD_W-1:0]  radius,
  input  logic [pbps_pkg::BOX_W-1:0]           box,
  output pbps_pkg::dist_stat_t                 stat
);

  localparam int CW = pbps_pkg::COORD_W;

  logic signed [CW-1:0]            px_r, py_r, pz_r, rad_r;
  logic [pbps_pkg::GAP_W-1:0]      gap_r;
  logic [pbps_pkg::ACC_W-1:0]      acc_r;
  logic [pbps_pkg::R2_W-1:0]       r2_r;

  logic signed [CW-1:0]            lo, hi, q;
  logic signed [CW:0]              dlo, dhi;
  logic [pbps_pkg::GAP_W-1:0]      glo, ghi, gap_nxt;
  logic [pbps_pkg::GAP_W-1:0]      mul_a;
  logic [pbps_pkg::PROD_W-1:0]     prod;

  // Pick one axis of the box and of the point.
  always_comb begin
    case (ctrl.axis)
      2'd0: begin
        lo = box[0*CW +: CW];
        hi = box[3*CW +: CW];
        q  = px_r;
      end
      2'd1: begin
        lo = box[1*CW +: CW];
        hi = box[4*CW +: CW];
        q  = py_r;
      end
      2'd2: begin
        lo = box[2*CW +: CW];
        hi = box[5*CW +: CW];
        q  = pz_r;
      end
      default: begin
        lo = '0;
        hi = '0;
        q  = '0;
      end
    endcase
  end

  // Gap below the min plus gap above the max; both count on an inverted box.
  always_comb begin
    dlo     = {lo[CW-1], lo} - {q[CW-1], q};
    dhi     = {q[CW-1], q} - {hi[CW-1], hi};
    glo     = (!dlo[CW] && (dlo != '0)) ? {1'b0, dlo[CW-1:0]} : '0;
    ghi     = (!dhi[CW] && (dhi != '0)) ? {1'b0, dhi[CW-1:0]} : '0;
    gap_nxt = glo + ghi;
  end

  // Shared squarer: radius once per query, then one gap per cycle in the axis steps.
  assign mul_a = ctrl.sq_radius ? {1'b0, rad_r} : gap_r;
  assign prod  = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (ctrl.load_q) begin
      px_r  <= point_x;
      py_r  <= point_y;
      pz_r  <= point_z;
      rad_r <= radius;
    end
    if (ctrl.sq_radius) begin
      r2_r <= prod[pbps_pkg::R2_W-1:0];
    end
    if (ctrl.gap_en) begin
      gap_r <= gap_nxt;
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + pbps_pkg::ACC_W'(prod);
    end
  end

  assign stat.match = (acc_r <= {{(pbps_pkg::ACC_W - pbps_pkg::R2_W){1'b0}}, r2_r});
  assign stat.r_neg = rad_r[CW-1];

endmodule

[sv/point_box_proximity_scan.sv]
`timescale 1ns / 1ps
// Load item: no result; the next item is taken the cycle after. Query item: the radius
// is squared, then each stored box is read, its axes pass one per cycle through the
// shared gap/square unit and the sum is compared; a flush step ends the query, straight
// after the radius for a negative radius or empty store. Results leave through an output
// register; a hit stalls the scan while it is full. Reset (rst_n, synchronous, active
// low) clears the sequencer, output valid and box count; the box store is not cleared.
module point_box_proximity_scan (
  input  logic      clk,
  input  logic      rst_n,
  pbps_in_if.sink   in_item,
  pbps_out_if.source out_item
);

  pbps_pkg::state_t                state_r, state_nxt;
  logic [pbps_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [pbps_pkg::SLOT_W-1:0]     idx_r, idx_nxt;
  logic [1:0]                      ax_r, ax_nxt;
  logic                            pend_v_r, pend_v_nxt;
  logic [pbps_pkg::SLOT_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [pbps_pkg::SLOT_W-1:0]     out_index_r, out_index_nxt;
  logic                            out_hit_r, out_hit_nxt;
  logic                            out_last_r, out_last_nxt;

  pbps_pkg::dist_ctrl_t            ctrl;
  pbps_pkg::dist_stat_t            stat;
  logic                            accept, out_free, ram_we, scan_end;
  logic [pbps_pkg::BOX_W-1:0]      wr_box, rd_box;
  logic [pbps_pkg::CNT_W-1:0]      idx_inc;

  assign in_item.ready = (state_r == pbps_pkg::S_IDLE);
  assign accept        = in_item.valid && in_item.ready;
  assign out_free      = !out_valid_r || out_item.ready;
  assign idx_inc       = {1'b0, idx_r} + pbps_pkg::CNT_W'(1);
  assign scan_end      = (idx_inc == count_r);

  assign ram_we = accept && (in_item.op == pbps_pkg::OP_LOAD) &&
                  ({1'b0, in_item.slot} < pbps_pkg::CNT_W'(pbps_pkg::MAX_BOXES));
  assign wr_box = {in_item.box_max_z, in_item.box_max_y, in_item.box_max_x,
                   in_item.box_min_z, in_item.box_min_y, in_item.box_min_x};

  pbps_ram #(
    .WIDTH(pbps_pkg::BOX_W),
    .DEPTH(pbps_pkg::MAX_BOXES)
  ) u_box_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(in_item.slot[pbps_pkg::ADDR_W-1:0]),
    .wr_data(wr_box),
    .rd_addr(idx_r[pbps_pkg::ADDR_W-1:0]),
    .rd_data(rd_box)
  );

  pbps_dist_unit u_dist (
    .clk    (clk),
    .ctrl   (ctrl),
    .point_x(in_item.point_x),
    .point_y(in_item.point_y),
    .point_z(in_item.point_z),
    .radius (in_item.radius),
    .box    (rd_box),
    .stat   (stat)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    ax_nxt        = ax_r;
    pend_v_nxt    = pend_v_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_index_nxt = out_index_r;
    out_hit_nxt   = out_hit_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;

    case (state_r)
      pbps_pkg::S_IDLE: begin
        if (accept) begin
          if (in_item.op == pbps_pkg::OP_QUERY) begin
            ctrl.load_q = 1'b1;
            state_nxt   = pbps_pkg::S_RSQ;
          end else if (ram_we) begin
            count_nxt = {1'b0, in_item.slot} + pbps_pkg::CNT_W'(1);
          end
        end
      end
      pbps_pkg::S_RSQ: begin
        ctrl.sq_radius = 1'b1;
        idx_nxt        = '0;
        pend_v_nxt     = 1'b0;
        if (stat.r_neg || (count_r == '0)) begin
          state_nxt = pbps_pkg::S_FLUSH;
        end else begin
          state_nxt = pbps_pkg::S_READ;
        end
      end
      pbps_pkg::S_READ: begin
        ax_nxt    = 2'd0;
        state_nxt = pbps_pkg::S_AXIS;
      end
      pbps_pkg::S_AXIS: begin
        // Gap of this axis into the register while the previous gap is squared.
        ctrl.axis    = ax_r;
        ctrl.gap_en  = (ax_r != 2'd3);
        ctrl.acc_clr = (ax_r == 2'd0);
        ctrl.acc_en  = (ax_r != 2'd0);
        ax_nxt       = ax_r + 2'd1;
        if (ax_r == 2'd3) begin
          state_nxt = pbps_pkg::S_CMP;
        end
      end
      pbps_pkg::S_CMP: begin
        if (stat.match && pend_v_r && !out_free) begin
          state_nxt = pbps_pkg::S_CMP;  // hold until the output register frees
        end else begin
          if (stat.match) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_index_nxt = pend_idx_r;
              out_hit_nxt   = 1'b1;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = idx_r;
          end
          if (scan_end) begin
            state_nxt = pbps_pkg::S_FLUSH;
          end else begin
            idx_nxt   = idx_inc[pbps_pkg::SLOT_W-1:0];
            state_nxt = pbps_pkg::S_READ;
          end
        end
      end
      pbps_pkg::S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = pend_v_r ? pend_idx_r : '0;
          out_hit_nxt   = pend_v_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = pbps_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pbps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbps_pkg::S_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    ax_r        <= ax_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_index_r <= out_index_nxt;
    out_hit_r   <= out_hit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.box_index = out_index_r;
  assign out_item.hit       = out_hit_r;
  assign out_item.last      = out_last_r;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pbps_pkg::S_IDLE) |-> !pend_v_r)
    else $error("pending hit left behind after a query");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> out_last_r)
    else $error("empty result not marked last");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pbps_pkg::CNT_W'(pbps_pkg::MAX_BOXES))
    else $error("box count above capacity");
`endif

endmodule
